// ----- rtl/tks_pkg.sv -----
// ----------------------------------------------------------------------------
// tks_pkg
// shared types and constants of the per-layer top-k energy sorter
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int CNT_W = 4;

  localparam logic [CNT_W-1:0] CFG_LAYERS_RST = 4'd8;
  localparam logic [CNT_W-1:0] CFG_SLOTS_RST  = 4'd8;

  typedef enum logic {
    REG_LAYERS = 1'b0,
    REG_SLOTS  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] energy;
    logic [31:0] tag;
  } slot_t;

  typedef struct packed {
    logic             kept;
    logic [CNT_W-1:0] fill;
  } ins_st_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS,
    ST_ERD,
    ST_EMIT
  } st_t;

endpackage

// ----- rtl/tks_if.sv -----
// ----------------------------------------------------------------------------
// tks_hit_if / tks_res_if
// valid/ready channels carrying hit words and result words
// ----------------------------------------------------------------------------
interface tks_hit_if;
  logic        valid;
  logic        ready;
  logic        hit_valid;
  logic [7:0]  layer;
  logic [31:0] energy;
  logic [31:0] hit_tag;
  logic        end_of_event;

  modport source (output valid, hit_valid, layer, energy, hit_tag, end_of_event,
                  input ready);
  modport sink (input valid, hit_valid, layer, energy, hit_tag, end_of_event,
                output ready);
endinterface

interface tks_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_layer;
  logic [31:0] out_energy;
  logic [31:0] out_tag;
  logic        is_padding;
  logic        last_of_event;

  modport source (output valid, out_layer, out_energy, out_tag, is_padding,
                  last_of_event, input ready);
  modport sink (input valid, out_layer, out_energy, out_tag, is_padding,
                last_of_event, output ready);
endinterface

// ----- rtl/tks_ram.sv -----
// ----------------------------------------------------------------------------
// tks_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module tks_ram #(
  parameter int W = 64,
  parameter int D = 8,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/tks_ins.sv -----
// ----------------------------------------------------------------------------
// tks_ins
// sorted insertion of one hit into a layer row
// ----------------------------------------------------------------------------
module tks_ins #(
  parameter int MAX_SLOTS = 8
) (
  input  tks_pkg::slot_t                row_in  [MAX_SLOTS],
  input  logic [31:0]                   energy,
  input  logic [31:0]                   tag,
  input  logic [tks_pkg::CNT_W-1:0]     fill,
  input  logic [tks_pkg::CNT_W-1:0]     ns,
  output tks_pkg::slot_t                row_out [MAX_SLOTS],
  output tks_pkg::ins_st_t              st
);
  import tks_pkg::*;

  logic [CNT_W-1:0] f;
  logic [CNT_W-1:0] pos;

  always_comb begin
    f = (fill < ns) ? fill : ns;
    pos = f;
    for (int j = MAX_SLOTS - 1; j >= 0; j--) begin
      if (CNT_W'(j) < f && $signed(energy) > $signed(row_in[j].energy)) begin
        pos = CNT_W'(j);
      end
    end
    for (int j = 0; j < MAX_SLOTS; j++) begin
      if (CNT_W'(j) < pos) begin
        row_out[j] = row_in[j];
      end else if (CNT_W'(j) == pos) begin
        row_out[j] = '{energy: energy, tag: tag};
      end else begin
        row_out[j] = row_in[(j > 0) ? j - 1 : 0];
      end
    end
    st.kept = pos < ns;
    st.fill = (st.kept && f < ns) ? f + 1'b1 : f;
  end

endmodule

// ----- rtl/tks_cfg.sv -----
// ----------------------------------------------------------------------------
// tks_cfg
// apb register file with clamped effective layer and slot counts
// ----------------------------------------------------------------------------
module tks_cfg #(
  parameter int MAX_LAYERS = 8,
  parameter int MAX_SLOTS  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [tks_pkg::CNT_W-1:0]     nl,
  output logic [tks_pkg::CNT_W-1:0]     ns
);
  import tks_pkg::*;

  logic [CNT_W-1:0] layers_r;
  logic [CNT_W-1:0] slots_r;
  logic             wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layers_r <= CFG_LAYERS_RST;
      slots_r  <= CFG_SLOTS_RST;
    end else if (wr) begin
      if (paddr[2] == REG_LAYERS) begin
        layers_r <= pwdata[CNT_W-1:0];
      end else begin
        slots_r <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = (paddr[2] == REG_LAYERS) ? 32'(layers_r) : 32'(slots_r);
    if (layers_r == '0) nl = CNT_W'(1);
    else if (layers_r > CNT_W'(MAX_LAYERS)) nl = CNT_W'(MAX_LAYERS);
    else nl = layers_r;
    if (slots_r == '0) ns = CNT_W'(1);
    else if (slots_r > CNT_W'(MAX_SLOTS)) ns = CNT_W'(MAX_SLOTS);
    else ns = slots_r;
  end

endmodule

// ----- rtl/per_layer_top_k_energy_sorter_unit.sv -----
// ----------------------------------------------------------------------------
// per_layer_top_k_energy_sorter_unit
// keeps the highest-energy hits of each layer and emits them per event
// ----------------------------------------------------------------------------
// in_ch takes one hit word per handshake; out_ch gives one slot word per
// handshake; cfg_* is an apb write/read port for layers_in_use (0x0) and
// slots_per_layer (0x4).
// each layer row lives in one ram entry. a word carrying a hit in a kept
// layer first reads the row, then sorted insertion writes it back. on
// end_of_event every layer row in use is read and its slots are sent one
// per cycle while out_ch is ready.
// in_ch.ready is low while an insertion or the drain runs.
// reset sets both registers to 8 and clears the fill counts; the ram is not
// cleared since only slots below the fill count are read.
// a stalled out_ch holds the output register and pauses the drain.
// ----------------------------------------------------------------------------
module per_layer_top_k_energy_sorter_unit #(
  parameter int MAX_LAYERS = 8,
  parameter int MAX_SLOTS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  tks_hit_if.sink     in_ch,
  tks_res_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tks_pkg::*;

  localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int RW = MAX_SLOTS * $bits(slot_t);

  logic [CNT_W-1:0] nl, ns;
  st_t              st_r, st_nxt;
  logic [LW-1:0]    lay_r, lay_nxt;
  logic [31:0]      e_r, e_nxt, tag_r, tag_nxt;
  logic             eoe_r, eoe_nxt;
  logic [LW-1:0]    k_r, k_nxt;
  logic [SW-1:0]    i_r, i_nxt;
  logic [CNT_W-1:0] fill_r [MAX_LAYERS];
  logic [CNT_W-1:0] fill_nxt [MAX_LAYERS];
  logic             ov_r, ov_nxt;
  slot_t            od_r, od_nxt;
  logic [2:0]       ol_r, ol_nxt;
  logic             op_r, op_nxt, olast_r, olast_nxt;

  logic             re, we, acc, load, last_i, last_k;
  logic [LW-1:0]    raddr;
  logic [RW-1:0]    rdata, wdata;
  slot_t            row_rd [MAX_SLOTS];
  slot_t            row_wr [MAX_SLOTS];
  ins_st_t          ist;
  logic [CNT_W-1:0] kfill;

  tks_cfg #(.MAX_LAYERS(MAX_LAYERS), .MAX_SLOTS(MAX_SLOTS)) u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .nl(nl), .ns(ns)
  );

  tks_ram #(.W(RW), .D(MAX_LAYERS)) u_ram (
    .clk(clk), .we(we), .waddr(lay_r), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    for (int j = 0; j < MAX_SLOTS; j++) begin
      row_rd[j] = rdata[j*$bits(slot_t) +: $bits(slot_t)];
      wdata[j*$bits(slot_t) +: $bits(slot_t)] = row_wr[j];
    end
  end

  tks_ins #(.MAX_SLOTS(MAX_SLOTS)) u_ins (
    .row_in(row_rd), .energy(e_r), .tag(tag_r), .fill(fill_r[lay_r]),
    .ns(ns), .row_out(row_wr), .st(ist)
  );

  assign in_ch.ready          = (st_r == ST_IDLE);
  assign acc                  = in_ch.valid && in_ch.ready;
  assign out_ch.valid         = ov_r;
  assign out_ch.out_layer     = ol_r;
  assign out_ch.out_energy    = od_r.energy;
  assign out_ch.out_tag       = od_r.tag;
  assign out_ch.is_padding    = op_r;
  assign out_ch.last_of_event = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
      for (int j = 0; j < MAX_LAYERS; j++) fill_r[j] <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lay_r   <= lay_nxt;
    e_r     <= e_nxt;
    tag_r   <= tag_nxt;
    eoe_r   <= eoe_nxt;
    k_r     <= k_nxt;
    i_r     <= i_nxt;
    od_r    <= od_nxt;
    ol_r    <= ol_nxt;
    op_r    <= op_nxt;
    olast_r <= olast_nxt;
  end

  always_comb begin
    st_nxt    = st_r;
    lay_nxt   = lay_r;
    e_nxt     = e_r;
    tag_nxt   = tag_r;
    eoe_nxt   = eoe_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    fill_nxt  = fill_r;
    ov_nxt    = ov_r && !out_ch.ready;
    od_nxt    = od_r;
    ol_nxt    = ol_r;
    op_nxt    = op_r;
    olast_nxt = olast_r;
    re        = 1'b0;
    we        = 1'b0;
    raddr     = in_ch.layer[LW-1:0];
    load      = 1'b0;
    kfill     = (fill_r[k_r] < ns) ? fill_r[k_r] : ns;
    last_i    = CNT_W'(i_r) == ns - 1'b1;
    last_k    = CNT_W'(k_r) == nl - 1'b1;
    case (st_r)
      ST_IDLE: begin
        if (acc) begin
          lay_nxt = in_ch.layer[LW-1:0];
          e_nxt   = in_ch.energy;
          tag_nxt = in_ch.hit_tag;
          eoe_nxt = in_ch.end_of_event;
          k_nxt   = '0;
          if (in_ch.hit_valid && {4'b0, nl} > in_ch.layer) begin
            re     = 1'b1;
            st_nxt = ST_INS;
          end else if (in_ch.end_of_event) begin
            st_nxt = ST_ERD;
          end
        end
      end
      ST_INS: begin
        we = ist.kept;
        fill_nxt[lay_r] = ist.fill;
        st_nxt = eoe_r ? ST_ERD : ST_IDLE;
      end
      ST_ERD: begin
        re     = 1'b1;
        raddr  = k_r;
        i_nxt  = '0;
        st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        load = !ov_r || out_ch.ready;
        if (load) begin
          ov_nxt    = 1'b1;
          ol_nxt    = 3'(k_r);
          op_nxt    = CNT_W'(i_r) >= kfill;
          od_nxt    = op_nxt ? '0 : row_rd[i_r];
          olast_nxt = last_i && last_k;
          i_nxt     = i_r + 1'b1;
          if (last_i) begin
            if (last_k) begin
              for (int j = 0; j < MAX_LAYERS; j++) fill_nxt[j] = '0;
              st_nxt = ST_IDLE;
            end else begin
              k_nxt  = k_r + 1'b1;
              st_nxt = ST_ERD;
            end
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> st_r == ST_IDLE)
    else $error("input accepted outside idle");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last_i && last_k) |=> fill_r[0] == '0 && st_r == ST_IDLE)
    else $error("fill counts not cleared after event");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_INS |-> ist.fill <= CNT_W'(MAX_SLOTS))
    else $error("fill count beyond slot storage");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && op_r) |-> od_r == '0)
    else $error("padding word carries data");

endmodule
